// ===== rtl/core/idea_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register codes and mod-65537 arithmetic for the IDEA core.
// No dependencies.
package idea_pkg;

	typedef logic [15:0] word_t;

	typedef struct packed {
		word_t x4;
		word_t x3;
		word_t x2;
		word_t x1;
	} blk_t;

	typedef logic [1:0] cfg_idx_t;

	localparam cfg_idx_t REG_KEY_LOW  = 2'd0;
	localparam cfg_idx_t REG_KEY_HIGH = 2'd1;
	localparam cfg_idx_t REG_MODE     = 2'd2;

	// full expanded key length, independent of round count
	localparam int NZ = 52;
	// last step of one inverse: load, then 15 square/multiply pairs
	localparam logic [4:0] INV_LAST = 5'd30;

	typedef enum logic {
		KS_IDLE,
		KS_BUSY
	} ks_state_t;

	// a*b mod 65537 for operands in 1..65536
	function automatic logic [16:0] mulmod17(input logic [16:0] a, input logic [16:0] b);
		logic [33:0] p;
		logic [15:0] lo;
		logic [16:0] hi;
		logic [17:0] r;
		p  = a * b;
		lo = p[15:0];
		hi = p[32:16];
		// 65536 == -1 mod 65537
		r  = {2'b00, lo} - {1'b0, hi};
		if ({1'b0, lo} < hi)
			r = r + 18'd65537;
		return r[16:0];
	endfunction

	function automatic logic [16:0] expand17(input word_t a);
		return (a == 16'd0) ? 17'h10000 : {1'b0, a};
	endfunction

	function automatic word_t mul16(input word_t a, input word_t b);
		logic [16:0] r;
		r = mulmod17(expand17(a), expand17(b));
		return r[15:0];
	endfunction

endpackage

// ===== rtl/core/idea_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result blocks.
// No dependencies.
interface idea_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_in;

	modport source(output valid, output block_in, input ready);
	modport sink(input valid, input block_in, output ready);
	modport mon(input valid, input block_in, input ready);
endinterface

interface idea_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_out;

	modport source(output valid, output block_out, input ready);
	modport sink(input valid, input block_out, output ready);
	modport mon(input valid, input block_out, input ready);
endinterface

// ===== rtl/core/idea_ks.sv =====
`timescale 1ns / 1ps
// Key registers and subkey schedule; decrypt inverses by a shared
// square-and-multiply unit. Depends on idea_pkg.
module idea_ks import idea_pkg::*; #(
	parameter int ROUNDS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  cfg_idx_t                    cfg_index,
	input  logic [63:0]                 cfg_data,
	output word_t [6*ROUNDS+3:0]        tbl,
	output logic                        busy
);

	localparam int NK   = 6 * ROUNDS + 4;
	localparam int NINV = 2 * (ROUNDS + 1);
	localparam int IW   = $clog2(NINV);

	logic [63:0] key_low_q, key_high_q;
	logic        mode_q;
	ks_state_t   state_q, state_nxt;
	logic [IW-1:0] idx_q;
	logic [4:0]  cnt_q;
	logic [16:0] acc_q;
	word_t       inv_q [NINV];

	word_t       z    [NZ];
	word_t       srcs [NINV];
	logic [16:0] src17, opb, prod;
	logic        start, last_step;

	assign start     = cfg_we && (cfg_index <= REG_MODE);
	assign last_step = (cnt_q == INV_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			mode_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_MODE:     mode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// expanded key: 25-bit rotations of the user key, pure wiring
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			z[i]     = key_low_q[16*i +: 16];
			z[i + 4] = key_high_q[16*i +: 16];
		end
		for (int i = 8; i < NZ; i++) begin
			case (i % 8)
				6:       z[i] = {z[i-14][8:0], z[i-7][15:9]};
				7:       z[i] = {z[i-14][8:0], z[i-15][15:9]};
				default: z[i] = {z[i-6][8:0], z[i-7][15:9]};
			endcase
		end
		for (int r = 0; r <= ROUNDS; r++) begin
			srcs[2*r]     = z[6*(ROUNDS-r)];
			srcs[2*r + 1] = z[6*(ROUNDS-r) + 3];
		end
	end

	assign src17 = expand17(srcs[idx_q]);
	// odd steps square, even steps multiply by the source
	assign opb   = cnt_q[0] ? acc_q : src17;
	assign prod  = mulmod17(acc_q, opb);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			KS_IDLE: if (start) state_nxt = KS_BUSY;
			KS_BUSY: begin
				if (!start && last_step && idx_q == IW'(NINV - 1))
					state_nxt = KS_IDLE;
			end
			default: state_nxt = KS_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			KS_BUSY: busy = 1'b1;
			default: busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KS_BUSY;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (start) begin
				idx_q <= '0;
				cnt_q <= '0;
			end else if (state_q == KS_BUSY) begin
				if (last_step) begin
					cnt_q <= '0;
					idx_q <= idx_q + 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_q == 5'd0)
			acc_q <= src17;
		else
			acc_q <= prod;
		if (state_q == KS_BUSY && last_step && !start)
			inv_q[idx_q] <= prod[15:0];
	end

	always_comb begin
		for (int i = 0; i < NK; i++)
			tbl[i] = z[i];
		if (mode_q) begin
			for (int r = 0; r <= ROUNDS; r++) begin
				tbl[6*r]     = inv_q[2*r];
				tbl[6*r + 3] = inv_q[2*r + 1];
				if (r == 0 || r == ROUNDS) begin
					tbl[6*r + 1] = 16'd0 - z[6*(ROUNDS-r) + 1];
					tbl[6*r + 2] = 16'd0 - z[6*(ROUNDS-r) + 2];
				end else begin
					tbl[6*r + 1] = 16'd0 - z[6*(ROUNDS-r) + 2];
					tbl[6*r + 2] = 16'd0 - z[6*(ROUNDS-r) + 1];
				end
				if (r < ROUNDS) begin
					tbl[6*r + 4] = z[6*(ROUNDS-r) - 2];
					tbl[6*r + 5] = z[6*(ROUNDS-r) - 1];
				end
			end
		end
	end

endmodule

// ===== rtl/core/idea_round.sv =====
`timescale 1ns / 1ps
// One IDEA round as three elastic register stages, one multiply level each.
// Depends on idea_pkg.
module idea_round import idea_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  blk_t        in_blk,
	input  word_t [5:0] k,
	output logic        out_valid,
	input  logic        out_ready,
	output blk_t        out_blk
);

	blk_t  x_s1, x_s2, x_s3;
	word_t t2_s2;
	logic  v_s1, v_s2, v_s3;
	logic  en1, en2, en3;
	word_t t1, u;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	assign t1 = mul16(t2_s2 + (x_s2.x2 ^ x_s2.x4), k[5]);
	assign u  = t1 + t2_s2;

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1.x1 <= mul16(in_blk.x1, k[0]);
			x_s1.x2 <= in_blk.x2 + k[1];
			x_s1.x3 <= in_blk.x3 + k[2];
			x_s1.x4 <= mul16(in_blk.x4, k[3]);
		end
		if (en2) begin
			x_s2  <= x_s1;
			t2_s2 <= mul16(x_s1.x1 ^ x_s1.x3, k[4]);
		end
		if (en3) begin
			x_s3.x1 <= x_s2.x1 ^ t1;
			x_s3.x4 <= x_s2.x4 ^ u;
			// middle words swap
			x_s3.x2 <= x_s2.x3 ^ t1;
			x_s3.x3 <= u ^ x_s2.x2;
		end
	end

	assign out_valid = v_s3;
	assign out_blk   = x_s3;

endmodule

// ===== rtl/core/idea_block_cipher.sv =====
`timescale 1ns / 1ps
// IDEA ECB core. One block per cycle sustained while the key schedule is idle
// and dout.ready is high; three multiply stages per round plus the output
// transform stage. After reset and after every key or mode write, din.ready
// stays low while the shared mod-65537 unit builds the decrypt inverses.
// Reset is asynchronous; key and mode reset to zero.
module idea_block_cipher import idea_pkg::*; #(
	parameter int ROUNDS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	idea_in_if.sink       din,
	idea_out_if.source    dout,
	input  logic          cfg_we,
	input  cfg_idx_t      cfg_index,
	input  logic [63:0]   cfg_data
);

	localparam int NK = 6 * ROUNDS + 4;

	word_t [NK-1:0] tbl;
	logic           busy;
	blk_t           rb [ROUNDS+1];
	logic           rv [ROUNDS+1];
	logic           rr [ROUNDS+1];
	logic           vo_q;
	logic [63:0]    out_q;
	blk_t           fb;

	idea_ks #(.ROUNDS(ROUNDS)) u_ks (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tbl       (tbl),
		.busy      (busy)
	);

	assign rb[0]     = din.block_in;
	assign rv[0]     = din.valid && !busy;
	assign din.ready = rr[0] && !busy;

	for (genvar r = 0; r < ROUNDS; r++) begin : g_rnd
		idea_round u_rnd (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (rv[r]),
			.in_ready  (rr[r]),
			.in_blk    (rb[r]),
			.k         (tbl[6*r +: 6]),
			.out_valid (rv[r+1]),
			.out_ready (rr[r+1]),
			.out_blk   (rb[r+1])
		);
	end

	assign fb       = rb[ROUNDS];
	assign rr[ROUNDS] = !vo_q || dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vo_q <= 1'b0;
		else if (rr[ROUNDS])
			vo_q <= rv[ROUNDS];
	end

	// output transform undoes the last swap
	always_ff @(posedge clk) begin
		if (rr[ROUNDS]) begin
			out_q[15:0]  <= mul16(fb.x1, tbl[6*ROUNDS]);
			out_q[31:16] <= fb.x3 + tbl[6*ROUNDS + 1];
			out_q[47:32] <= fb.x2 + tbl[6*ROUNDS + 2];
			out_q[63:48] <= mul16(fb.x4, tbl[6*ROUNDS + 3]);
		end
	end

	assign dout.valid     = vo_q;
	assign dout.block_out = out_q;

endmodule

// ===== rtl/core/idea_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks for idea_block_cipher, attached by bind.
// Depends on idea_pkg and idea_if.
module idea_chk import idea_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      din_valid,
	input  logic      din_ready,
	input  logic      dout_valid,
	input  logic      dout_ready,
	input  logic      cfg_we,
	input  cfg_idx_t  cfg_index
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dout_valid && !dout_ready |=> dout_valid)
		else $error("result dropped while stalled");

	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_HIGH ||
			cfg_index == REG_MODE) |=> !din_ready)
		else $error("request taken right after key write");

	a_cfg_stall2: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_HIGH ||
			cfg_index == REG_MODE) |-> ##2 !din_ready)
		else $error("key schedule finished too early");

endmodule

bind idea_block_cipher idea_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.din_valid  (din.valid),
	.din_ready  (din.ready),
	.dout_valid (dout.valid),
	.dout_ready (dout.ready),
	.cfg_we     (cfg_we),
	.cfg_index  (cfg_index)
);

// ===== dv/tb_idea_block_cipher.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the IDEA ECB core: random and directed blocks under several keys and modes.
// Depends on idea_pkg, idea_in_if, idea_out_if and the idea_block_cipher RTL.
module tb_idea_block_cipher;
	import idea_pkg::*;

	localparam int NR = 8;
	localparam int NK = 6 * NR + 4;
	localparam int LATENCY = 3 * NR + 1;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [63:0] cfg_data;

	idea_in_if din();
	idea_out_if dout();

	idea_block_cipher #(.ROUNDS(NR)) dut (
		.clk(clk), .arst_n(arst_n), .din(din.sink), .dout(dout.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [63:0] key_lo_m, key_hi_m;
	logic mode_m;
	word_t sk[NK];

	logic [63:0] pending_blocks[$];
	logic [63:0] expected_blocks[$];
	int errors = 0;
	int blocks_seen = 0;
	int configs_done = 0;
	longint cycles = 0;
	bit drain_hold = 0;
	int hold_long = 0;

	function automatic word_t mmul(word_t a, word_t b);
		longint unsigned aa, bb;
		aa = (a == 0) ? 65536 : a;
		bb = (b == 0) ? 65536 : b;
		return word_t'((aa * bb) % 65537);
	endfunction

	function automatic word_t minv(word_t a);
		longint unsigned base, res;
		int e;
		base = (a == 0) ? 65536 : a;
		res = 1;
		e = 65535;
		while (e != 0) begin
			if (e & 1) res = (res * base) % 65537;
			base = (base * base) % 65537;
			e = e >> 1;
		end
		return word_t'(res);
	endfunction

	task automatic expand_key();
		word_t z[52];
		int j, b, d;
		logic [31:0] lo, hi;
		for (int i = 0; i < 4; i++) begin
			z[i] = key_lo_m[16*i +: 16];
			z[i+4] = key_hi_m[16*i +: 16];
		end
		for (int i = 8; i < 52; i++) begin
			j = i & 7;
			if (j < 6) begin
				lo = z[i-7]; hi = z[i-6];
			end else if (j == 6) begin
				lo = z[i-7]; hi = z[i-14];
			end else begin
				lo = z[i-15]; hi = z[i-14];
			end
			z[i] = word_t'((lo >> 9) | (hi << 7));
		end
		if (!mode_m) begin
			for (int i = 0; i < NK; i++) sk[i] = z[i];
		end else begin
			for (int r = 0; r <= NR; r++) begin
				b = 6 * (NR - r);
				d = 6 * r;
				sk[d] = minv(z[b]);
				if (r == 0 || r == NR) begin
					sk[d+1] = -z[b+1];
					sk[d+2] = -z[b+2];
				end else begin
					sk[d+1] = -z[b+2];
					sk[d+2] = -z[b+1];
				end
				sk[d+3] = minv(z[b+3]);
				if (r < NR) begin
					sk[d+4] = z[b-2];
					sk[d+5] = z[b-1];
				end
			end
		end
	endtask

	function automatic logic [63:0] cipher_block(logic [63:0] blk);
		word_t x1, x2, x3, x4, t1, t2, s;
		int k;
		x1 = blk[15:0]; x2 = blk[31:16]; x3 = blk[47:32]; x4 = blk[63:48];
		k = 0;
		for (int r = 0; r < NR; r++) begin
			x1 = mmul(x1, sk[k]);
			x2 = x2 + sk[k+1];
			x3 = x3 + sk[k+2];
			x4 = mmul(x4, sk[k+3]);
			t2 = mmul(x1 ^ x3, sk[k+4]);
			t1 = mmul(t2 + (x2 ^ x4), sk[k+5]);
			t2 = t1 + t2;
			x1 = x1 ^ t1;
			x4 = x4 ^ t2;
			s = t2 ^ x2;
			x2 = x3 ^ t1;
			x3 = s;
			k += 6;
		end
		x1 = mmul(x1, sk[k]);
		x3 = x3 + sk[k+1];
		x2 = x2 + sk[k+2];
		x4 = mmul(x4, sk[k+3]);
		return {x4, x2, x3, x1};
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at cycle %0d", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// driver: prediction is made at acceptance, using the current key table
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din.valid <= 1'b0;
			din.block_in <= '0;
			send_gap <= 0;
		end else begin
			// the accepted request leaves the queue here, so the head is always next
			if (din.valid && din.ready) begin
				expected_blocks.push_back(cipher_block(din.block_in));
				void'(pending_blocks.pop_front());
			end
			if (din.valid && !din.ready) begin
				// keep holding the request
			end else if (send_gap > 0) begin
				din.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_blocks.size() != 0 && !drain_hold) begin
				din.valid <= 1'b1;
				din.block_in <= pending_blocks[0];
				if ($urandom_range(0, 3) == 0)
					send_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
						: $urandom_range(1, 3);
			end else begin
				din.valid <= 1'b0;
			end
		end
	end

	// monitor plus receiver back-pressure
	int recv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (dout.valid && dout.ready) begin
				blocks_seen <= blocks_seen + 1;
				if (expected_blocks.size() == 0) begin
					errors <= errors + 1;
					$display("%0t unexpected result %h", $time, dout.block_out);
				end else begin
					if (dout.block_out !== expected_blocks[0]) begin
						errors <= errors + 1;
						$display("%0t block_out mismatch: expected %h actual %h",
							$time, expected_blocks[0], dout.block_out);
					end
					void'(expected_blocks.pop_front());
				end
			end
			if (hold_long > 0) begin
				dout.ready <= 1'b0;
				hold_long <= hold_long - 1;
			end else if (recv_gap > 0) begin
				dout.ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				dout.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					recv_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
						: $urandom_range(1, 3);
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KEY_LOW: key_lo_m = val;
			REG_KEY_HIGH: key_hi_m = val;
			REG_MODE: mode_m = val[0];
			default: ;
		endcase
		expand_key();
		configs_done++;
	endtask

	task automatic wait_idle();
		while (pending_blocks.size() != 0 || expected_blocks.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic queue_random(int n);
		logic [63:0] v;
		for (int i = 0; i < n; i++) begin
			v = {$urandom, $urandom};
			case ($urandom_range(0, 9))
				0: v[15:0] = '0;
				1: v[63:48] = 16'($urandom_range(0, 1));
				2: v = {v[63:32], 32'h0};
				default: ;
			endcase
			pending_blocks.push_back(v);
		end
	endtask

	task automatic setup(logic [63:0] kl, logic [63:0] kh, logic m);
		wait_idle();
		write_reg(REG_KEY_LOW, kl);
		write_reg(REG_KEY_HIGH, kh);
		write_reg(REG_MODE, {63'($urandom), m});
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_KEY_LOW;
		cfg_data = '0;
		din.valid = 0;
		din.block_in = '0;
		dout.ready = 0;
		key_lo_m = '0;
		key_hi_m = '0;
		mode_m = 0;
		expand_key();
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// directed: reset key (all zero), field extremes
		pending_blocks.push_back(64'h0);
		pending_blocks.push_back('1);
		pending_blocks.push_back(64'h0001_0001_0001_0001);
		pending_blocks.push_back(64'h8000_0000_ffff_0001);
		pending_blocks.push_back(64'h5555_aaaa_5555_aaaa);
		// all-ones key encrypt, then decrypt under small and zero keys (inverse of zero and one subkeys)
		setup('1, '1, 0);
		pending_blocks.push_back(64'h0);
		pending_blocks.push_back('1);
		pending_blocks.push_back(64'h0123_4567_89ab_cdef);
		setup(64'h0004_0003_0002_0001, 64'h0008_0007_0006_0005, 1);
		pending_blocks.push_back(64'h0);
		pending_blocks.push_back('1);
		pending_blocks.push_back(64'h0001_0000_0001_0000);
		// out-of-range register index: ignored
		wait_idle();
		write_reg(cfg_idx_t'(3), '1);
		pending_blocks.push_back(64'hdead_beef_0000_ffff);
		setup(64'h0, 64'h0, 1);
		pending_blocks.push_back(64'h0);
		pending_blocks.push_back('1);

		// random phases over several keys and modes
		for (int ph = 0; ph < 8; ph++) begin
			setup({$urandom, $urandom}, {$urandom, $urandom}, ph[0]);
			queue_random(80);
			if (ph == 3) begin
				// receiver stall long enough to fill the pipe and stall input
				while (pending_blocks.size() > 60) @(posedge clk);
				hold_long = 200;
			end
			if (ph == 5) begin
				while (pending_blocks.size() > 40) @(posedge clk);
				drain_hold = 1;
				while (expected_blocks.size() != 0 || din.valid) @(posedge clk);
				drain_hold = 0;
			end
		end
		wait_idle();
		queue_random(196);
		wait_idle();
		repeat (LATENCY * 2) @(posedge clk);
		$display("checked %0d result blocks across %0d register writes, both modes",
			blocks_seen, configs_done);
		if (errors == 0 && expected_blocks.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
